// ===== hw/rtl/sha_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 compression engine.
// No dependencies; every other file imports this package.
package sha_pkg;

   localparam int HASH_WORDS  = 8;
   localparam int BLOCK_WORDS = 16;
   localparam int ROUND_COUNT = 64;

   // Depth of the word queue between front and back; must be a power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [5:0] ROUND_LAST = 6'(ROUND_COUNT - 1);

   typedef struct packed {
      logic [31:0] message_word;
      logic        new_message;
      logic        final_block;
   } sha_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } sha_rsp_type;

   // One queued word, tagged by the front. The reload and emit flags are
   // meaningful on the word that closes a block.
   typedef struct packed {
      logic [31:0] message_word;
      logic        block_end;
      logic        reload;
      logic        emit;
   } sha_entry_type;

   typedef struct packed {
      logic valid;
      logic full;
   } sha_qstat_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } sha_state_type;

   function automatic logic [31:0] sha_iv(input logic [2:0] idx);
      logic [31:0] v;
      case (idx)
         3'd0:    v = 32'h6a09e667;
         3'd1:    v = 32'hbb67ae85;
         3'd2:    v = 32'h3c6ef372;
         3'd3:    v = 32'ha54ff53a;
         3'd4:    v = 32'h510e527f;
         3'd5:    v = 32'h9b05688c;
         3'd6:    v = 32'h1f83d9ab;
         default: v = 32'h5be0cd19;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] sha_k(input logic [5:0] idx);
      logic [31:0] v;
      case (idx)
         6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
         6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
         6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
         6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
         6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
         6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
         6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
         6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
         6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
         6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
         6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
         6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
         6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
         6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
         6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
         6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
         6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
         6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
         6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
         6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
         6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
         6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
         6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
         6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
         6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
         6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
         6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
         6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
         6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
         6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
         6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
         6'd62: v = 32'hbef9a3f7;
         default: v = 32'hc67178f2;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   function automatic logic [31:0] choose(input logic [31:0] s, input logic [31:0] p,
                                          input logic [31:0] q);
      return (s & p) ^ (~s & q);
   endfunction

   function automatic logic [31:0] majority(input logic [31:0] p, input logic [31:0] q,
                                            input logic [31:0] r);
      return (p & q) ^ (p & r) ^ (q & r);
   endfunction

endpackage

// ===== hw/rtl/sha_front.sv =====
// Front end: accepts message words, counts their place in the block and tags them.
// Depends on sha_pkg; feeds sha_queue.
module sha_front import sha_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  sha_req_type   req_data,
   input  sha_qstat_type q_status,
   output logic          q_push,
   output sha_entry_type q_entry
);

   logic [3:0] pos_ff, pos_in;
   logic       start_seen_ff, start_seen_in;
   logic       final_seen_ff, final_seen_in;
   logic       block_end;

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;
   assign block_end = (pos_ff == '1);

   // A start or final flag anywhere in a block applies to the whole block.
   assign q_entry.message_word = req_data.message_word;
   assign q_entry.block_end    = block_end;
   assign q_entry.reload       = start_seen_ff | req_data.new_message;
   assign q_entry.emit         = final_seen_ff | req_data.final_block;

   always_comb begin
      pos_in        = pos_ff;
      start_seen_in = start_seen_ff;
      final_seen_in = final_seen_ff;
      if (q_push) begin
         pos_in = pos_ff + 4'd1;
         if (block_end) begin
            start_seen_in = 1'b0;
            final_seen_in = 1'b0;
         end else begin
            start_seen_in = q_entry.reload;
            final_seen_in = q_entry.emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         start_seen_ff <= 1'b0;
         final_seen_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         start_seen_ff <= start_seen_in;
         final_seen_ff <= final_seen_in;
      end
   end

endmodule

// ===== hw/rtl/sha_queue.sv =====
// Short word queue that decouples the front end from the compression back end.
// Depends on sha_pkg.
module sha_queue import sha_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  sha_entry_type push_entry,
   input  logic          pop,
   output sha_entry_type pop_entry,
   output sha_qstat_type status
);

   sha_entry_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign pop_entry    = entry_ff[rd_ptr_ff];
   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hw/rtl/sha_back.sv =====
// Back end: loads a block from the queue, runs the 64 rounds one per cycle,
// updates the chaining value and sends out the digest. Depends on sha_pkg.
module sha_back import sha_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  sha_qstat_type q_status,
   input  sha_entry_type q_entry,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output sha_rsp_type   rsp_data
);

   sha_state_type state_ff, state_in;
   logic [5:0]    round_ff, round_in;
   logic [2:0]    idx_ff, idx_in;
   logic          emit_ff, emit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   sha_rsp_type   rsp_data_ff, rsp_data_in;
   logic [31:0]   chain_ff [HASH_WORDS];
   logic [31:0]   chain_in [HASH_WORDS];
   logic [31:0]   var_ff [HASH_WORDS];
   logic [31:0]   var_in [HASH_WORDS];
   logic [31:0]   win_ff [BLOCK_WORDS];
   logic [31:0]   win_in [BLOCK_WORDS];

   logic          out_load;
   logic          block_start;
   logic [31:0]   t1;
   logic [31:0]   t2;
   logic [31:0]   next_sched;

   // Outputs of the state machine.
   always_comb begin
      q_pop    = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         ST_LOAD: q_pop    = q_status.valid;
         ST_EMIT: out_load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   assign block_start = q_pop && q_entry.block_end;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (block_start) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_ff == ROUND_LAST) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = emit_ff ? ST_EMIT : ST_LOAD;
         end
         ST_EMIT: begin
            if (out_load && idx_ff == '1) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // The window holds W[t] .. W[t+15] with W[t] at entry 0.
   assign t1 = var_ff[7] + big_sigma1(var_ff[4]) + choose(var_ff[4], var_ff[5], var_ff[6])
             + sha_k(round_ff) + win_ff[0];
   assign t2 = big_sigma0(var_ff[0]) + majority(var_ff[0], var_ff[1], var_ff[2]);
   assign next_sched = small_sigma1(win_ff[14]) + win_ff[9] + small_sigma0(win_ff[1])
                     + win_ff[0];

   always_comb begin
      win_in   = win_ff;
      var_in   = var_ff;
      chain_in = chain_ff;
      round_in = '0;
      idx_in   = idx_ff;
      emit_in  = emit_ff;

      if (q_pop || state_ff == ST_ROUND) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[BLOCK_WORDS - 1] = q_pop ? q_entry.message_word : next_sched;
      end

      // A start flag in the block replaces the chaining value before compression.
      if (block_start) begin
         emit_in = q_entry.emit;
         for (int i = 0; i < HASH_WORDS; i++) begin
            var_in[i] = q_entry.reload ? sha_iv(3'(i)) : chain_ff[i];
            if (q_entry.reload) chain_in[i] = sha_iv(3'(i));
         end
      end

      if (state_ff == ST_ROUND) begin
         round_in  = round_ff + 6'd1;
         var_in[7] = var_ff[6];
         var_in[6] = var_ff[5];
         var_in[5] = var_ff[4];
         var_in[4] = var_ff[3] + t1;
         var_in[3] = var_ff[2];
         var_in[2] = var_ff[1];
         var_in[1] = var_ff[0];
         var_in[0] = t1 + t2;
      end

      if (state_ff == ST_UPDATE) begin
         idx_in  = '0;
         emit_in = 1'b0;
         for (int i = 0; i < HASH_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + var_ff[i];
         end
      end

      if (out_load) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.digest_word = chain_ff[idx_ff];
         rsp_data_in.word_index  = idx_ff;
         rsp_data_in.last_word   = (idx_ff == '1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         round_ff     <= '0;
         idx_ff       <= '0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < HASH_WORDS; i++) begin
            chain_ff[i] <= sha_iv(3'(i));
         end
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         idx_ff       <= idx_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      var_ff      <= var_in;
      win_ff      <= win_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/sha256_compression.sv =====
// Top level of the SHA-256 compression engine: front end, word queue, back end.
// Depends on sha_pkg, sha_front, sha_queue and sha_back.
//
//   channel  ports                          carries
//   req      req_valid, req_stall, req_data  one padded message word and flags
//   rsp      rsp_valid, rsp_stall, rsp_data  one digest word with its index
//
// The back end pulls one word a cycle from a four-word queue while the queue holds
// a word, then runs the 64 rounds one per cycle and adds into the chaining value
// in the update state; it compresses one 512-bit block at a time.
// A final block then sends the eight digest words, held while rsp_stall is high.
// Reset loads the initial hash; there is no clearing pass.
// The front accepts words into the queue while the back compresses, and stalls
// only when the queue is full; the digest waits in an output register.
module sha256_compression import sha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  sha_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output sha_rsp_type rsp_data
);

   sha_qstat_type q_status;
   sha_entry_type q_push_entry;
   sha_entry_type q_pop_entry;
   logic          q_push;
   logic          q_pop;

   sha_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_entry   (q_push_entry)
   );

   sha_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .pop_entry  (q_pop_entry),
      .status     (q_status)
   );

   sha_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_entry   (q_pop_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !q_push)
      else $error("word pushed into a full queue");

   a_queue_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !q_status.valid |-> !q_pop)
      else $error("word popped from an empty queue");

   a_last_word_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_index == '1)))
      else $error("last_word flag does not match the digest word index");

endmodule
